FILE: rtl/b64w_pkg.sv
// Package: shared types, constants and the base64 alphabet for the line-wrapping encoder.
`default_nettype none
package b64w_pkg;

	localparam int unsigned Q_DEPTH = 2;

	localparam logic [7:0] WRAP_LENGTH_RST = 8'd72;
	localparam logic       WRAP_ENABLE_RST = 1'b1;

	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [7:0] PAD_CHAR     = 8'h3D;
	localparam logic [7:0] LINE_STEP    = 8'd4;
	localparam logic [7:0] LINE_MAX     = 8'hFF;

	localparam logic [1:0] CFG_WRAP_LENGTH = 2'd0;
	localparam logic [1:0] CFG_WRAP_ENABLE = 2'd1;

	// one group of output characters, as handed from front to back
	typedef struct packed {
		logic [23:0] bits;     // three bytes, oldest in the top, missing bytes zero
		logic [1:0]  npad;     // trailing '=' count
		logic        nl;       // newline after the group
		logic        last;     // group closes the message
	} grp_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = 8'(8'h41 + {2'b00, v});
		end else if (v < 6'd52) begin
			c = 8'(8'h61 + {2'b00, v} - 8'd26);
		end else if (v < 6'd62) begin
			c = 8'(8'h30 + {2'b00, v} - 8'd52);
		end else if (v == 6'd62) begin
			c = 8'h2B;
		end else begin
			c = 8'h2F;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/b64w_in_if.sv
// Interface: raw byte request channel.
`default_nettype none
interface b64w_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       is_last;
	modport source(output valid, in_byte, is_last, input ready);
	modport sink(input valid, in_byte, is_last, output ready);
endinterface
`default_nettype wire

FILE: rtl/b64w_out_if.sv
// Interface: encoded character request channel.
`default_nettype none
interface b64w_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       out_last;
	modport source(output valid, out_char, out_last, input ready);
	modport sink(input valid, out_char, out_last, output ready);
endinterface
`default_nettype wire

FILE: rtl/b64w_cfg_if.sv
// Interface: configuration write channel.
`default_nettype none
interface b64w_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/b64w_front.sv
// Front end: gathers bytes into groups, tracks line length, emits group records.
`default_nettype none
module b64w_front
	import b64w_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	b64w_in_if.sink      byte_stream,
	b64w_cfg_if.sink     cfg,
	input  wire q_stat_t q_stat,
	output logic         push,
	output grp_t         push_grp
);

	logic [15:0] held_q;
	logic [1:0]  fill_q;
	logic [7:0]  line_q;
	logic [7:0]  wrap_len_q;
	logic        wrap_en_q;

	logic        accept;
	logic [8:0]  line_sum;
	logic [7:0]  line_new;

	assign cfg.ready         = 1'b1;
	assign byte_stream.ready = !q_stat.full;
	assign accept            = byte_stream.valid && byte_stream.ready;

	assign line_sum = {1'b0, line_q} + {1'b0, LINE_STEP};
	assign line_new = line_sum[8] ? LINE_MAX : line_sum[7:0];

	always_comb begin
		push_grp = '0;
		push     = accept && (fill_q == 2'd2 || byte_stream.is_last);
		unique case (fill_q)
			2'd2: begin
				push_grp.bits = {held_q, byte_stream.in_byte};
				push_grp.npad = 2'd0;
			end
			2'd1: begin
				push_grp.bits = {held_q[7:0], byte_stream.in_byte, 8'd0};
				push_grp.npad = 2'd1;
			end
			default: begin
				push_grp.bits = {byte_stream.in_byte, 16'd0};
				push_grp.npad = 2'd2;
			end
		endcase
		// with wrapping enabled a closing group always ends its line; otherwise wrap on length
		push_grp.nl   = wrap_en_q && (byte_stream.is_last || line_new >= wrap_len_q);
		push_grp.last = byte_stream.is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= '0;
			fill_q     <= '0;
			line_q     <= '0;
			wrap_len_q <= WRAP_LENGTH_RST;
			wrap_en_q  <= WRAP_ENABLE_RST;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == CFG_WRAP_LENGTH) begin
					wrap_len_q <= cfg.data;
				end
				if (cfg.index == CFG_WRAP_ENABLE) begin
					wrap_en_q <= cfg.data[0];
				end
			end
			if (accept) begin
				if (push) begin
					held_q <= '0;
					fill_q <= '0;
					line_q <= (push_grp.last || push_grp.nl) ? 8'd0 : line_new;
				end else begin
					held_q <= {held_q[7:0], byte_stream.in_byte};
					fill_q <= 2'(fill_q + 2'd1);
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/b64w_queue.sv
// Short FIFO of group records between front and back.
`default_nettype none
module b64w_queue
	import b64w_pkg::*;
#(
	parameter int unsigned DEPTH = Q_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire grp_t push_grp,
	input  wire logic pop,
	output grp_t      head,
	output q_stat_t   q_stat
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	grp_t          slot_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign head         = slot_q[rd_q];
	assign q_stat.full  = (cnt_q == CW'(DEPTH));
	assign q_stat.empty = (cnt_q == '0);

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= nxt(wr_q);
			end
			if (pop) begin
				rd_q <= nxt(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= CW'(cnt_q - 1'b1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/b64w_back.sv
// Back end: serializes one group record into characters through an output register.
`default_nettype none
module b64w_back
	import b64w_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire grp_t    head,
	input  wire q_stat_t q_stat,
	output logic         pop,
	b64w_out_if.source   char_stream
);

	logic       valid_q;
	logic [7:0] char_q;
	logic       last_q;
	logic [2:0] k_q;

	logic       advance;
	logic       load;
	logic       final_char;
	logic [5:0] sextet;
	logic [7:0] char_d;

	assign char_stream.valid    = valid_q;
	assign char_stream.out_char = char_q;
	assign char_stream.out_last = last_q;

	assign advance    = !valid_q || char_stream.ready;
	assign load       = advance && !q_stat.empty;
	assign final_char = head.nl ? (k_q == 3'd4) : (k_q == 3'd3);
	assign pop        = load && final_char;

	always_comb begin
		unique case (k_q)
			3'd0:    sextet = head.bits[23:18];
			3'd1:    sextet = head.bits[17:12];
			3'd2:    sextet = head.bits[11:6];
			default: sextet = head.bits[5:0];
		endcase
		if (k_q == 3'd4) begin
			char_d = NEWLINE_CHAR;
		end else if ((k_q == 3'd3 && head.npad != 2'd0) ||
				(k_q == 3'd2 && head.npad == 2'd2)) begin
			char_d = PAD_CHAR;
		end else begin
			char_d = b64_char(sextet);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= char_d;
			last_q <= head.last && final_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			k_q     <= '0;
		end else if (advance) begin
			valid_q <= !q_stat.empty;
			if (load) begin
				k_q <= final_char ? 3'd0 : 3'(k_q + 3'd1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/base64_encoder_line_wrap.sv
// Top level of the streaming base64 encoder with line wrapping.
// Raw bytes enter on byte_stream, one per request, with is_last marking the final byte
// of a message. Every third byte, and the last byte, closes a group that leaves on
// char_stream as four base64 characters ('=' padded for a short final group), then a
// newline when the line reaches wrap_length or the message ends (suppressed entirely
// when wrap_enable is 0). out_last flags the message's final character. Characters
// leave at one per cycle while the receiver is ready and a group record is waiting,
// from the back end's output register; a closed group passes through the queue and
// then that register before its first character appears. The front end keeps the
// partial group and line count and writes group records into a QUEUE_DEPTH-entry
// queue; byte requests stall only while that queue is full.
// Configuration (register 0: wrap_length, register 1: wrap_enable) is always ready and
// should be written between messages.
`default_nettype none
module base64_encoder_line_wrap
	import b64w_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = Q_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	b64w_in_if.sink    byte_stream,
	b64w_out_if.source char_stream,
	b64w_cfg_if.sink   cfg
);

	// front -> queue
	logic    push;
	grp_t    push_grp;
	// queue -> back
	grp_t    head;
	logic    pop;
	q_stat_t q_stat;

	b64w_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_stream (byte_stream),
		.cfg         (cfg),
		.q_stat      (q_stat),
		.push        (push),
		.push_grp    (push_grp)
	);

	b64w_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_grp (push_grp),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	b64w_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_stat      (q_stat),
		.pop         (pop),
		.char_stream (char_stream)
	);

endmodule
`default_nettype wire

FILE: rtl/b64w_checker.sv
// Port-level checker for the encoder, bound to the top level.
`default_nettype none
module b64w_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       in_last,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_char,
	input wire logic       out_last
);

	logic       seen_q;
	logic [3:0] open_q;
	logic       in_end;
	logic       out_end;

	assign in_end  = in_valid && in_ready && in_last;
	assign out_end = out_valid && out_ready && out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			open_q <= '0;
		end else begin
			if (in_valid && in_ready) begin
				seen_q <= 1'b1;
			end
			if (in_end && !out_end && open_q != 4'hF) begin
				open_q <= 4'(open_q + 4'd1);
			end else if (out_end && !in_end && open_q != 4'd0) begin
				open_q <= 4'(open_q - 4'd1);
			end
		end
	end

	// a stalled character holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
		else $error("output changed while stalled");

	// nothing leaves before anything was taken in
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> seen_q)
		else $error("output without input");

	// every end-of-message character answers a last byte already taken
	a_last_matched: assert property (@(posedge clk) disable iff (!arst_n)
		out_end |-> open_q != 4'd0)
		else $error("out_last without pending last byte");

endmodule

bind base64_encoder_line_wrap b64w_checker u_b64w_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (byte_stream.valid),
	.in_ready  (byte_stream.ready),
	.in_last   (byte_stream.is_last),
	.out_valid (char_stream.valid),
	.out_ready (char_stream.ready),
	.out_char  (char_stream.out_char),
	.out_last  (char_stream.out_last)
);
`default_nettype wire

FILE: bench/tb_base64_encoder_line_wrap.sv
// Testbench for the line-wrapping base64 encoder: directed and random traffic checked against a predictor.
`default_nettype none
module tb_base64_encoder_line_wrap;
	timeunit 1ns;
	timeprecision 1ps;

	import b64w_pkg::*;

	// cycles with no handshake on any channel before the run is declared hung
	localparam int STUCK_LIMIT = 3000;
	// receiver hold-off used to back the block up
	localparam int LONG_STALL = 300;
	// settle time after the last result, covers the front end finishing a silent byte
	localparam int SETTLE_CYCLES = 8;

	localparam logic [511:0] B64_SYMBOLS =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_req_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_req_t;

	logic clk;
	logic arst_n;

	b64w_in_if  byte_if();
	b64w_out_if char_if();
	b64w_cfg_if cfg_if();

	base64_encoder_line_wrap i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_stream(byte_if),
		.char_stream(char_if),
		.cfg        (cfg_if)
	);

	// stimulus and expectations
	byte_req_t pending_bytes [$];
	char_req_t expected_chars [$];
	byte_req_t next_req;
	int        mismatch_count;

	// idle rates in percent, set per phase
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	// long receiver hold-off
	logic stall_trigger;
	logic hold_rx;

	// predictor copy of the encoder state and its registers
	logic [15:0] held_bytes;
	logic [1:0]  group_fill;
	logic [7:0]  line_count;
	logic [7:0]  wrap_len;
	logic        wrap_en;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [7:0] alpha_of(input logic [5:0] v);
		return B64_SYMBOLS[8 * (63 - int'(v)) +: 8];
	endfunction

	// line count grows by one group, saturating at the top of the counter
	function automatic void advance_line();
		logic [8:0] sum;
		sum = {1'b0, line_count} + {1'b0, LINE_STEP};
		line_count = (sum > {1'b0, LINE_MAX}) ? LINE_MAX : sum[7:0];
	endfunction

	// Work out the characters one accepted byte causes and queue them.
	function automatic void encode_byte(input logic [7:0] b, input logic last);
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] chars [0:4];
		int         n;
		char_req_t  item;
		n = 0;
		if (group_fill == 2'd2) begin
			// third byte closes a full group
			b0 = held_bytes[15:8];
			b1 = held_bytes[7:0];
			chars[0] = alpha_of(b0[7:2]);
			chars[1] = alpha_of({b0[1:0], b1[7:4]});
			chars[2] = alpha_of({b1[3:0], b[7:6]});
			chars[3] = alpha_of(b[5:0]);
			n = 4;
			held_bytes = '0;
			group_fill = 2'd0;
			advance_line();
			if (wrap_en && line_count >= wrap_len) begin
				chars[n] = NEWLINE_CHAR;
				n++;
				line_count = '0;
			end
		end else begin
			held_bytes = {held_bytes[7:0], b};
			group_fill = group_fill + 2'd1;
		end
		if (last) begin
			if (group_fill == 2'd1) begin
				b0 = held_bytes[7:0];
				chars[n]     = alpha_of(b0[7:2]);
				chars[n + 1] = alpha_of({b0[1:0], 4'h0});
				chars[n + 2] = PAD_CHAR;
				chars[n + 3] = PAD_CHAR;
				n += 4;
				advance_line();
			end else if (group_fill == 2'd2) begin
				b0 = held_bytes[15:8];
				b1 = held_bytes[7:0];
				chars[n]     = alpha_of(b0[7:2]);
				chars[n + 1] = alpha_of({b0[1:0], b1[7:4]});
				chars[n + 2] = alpha_of({b1[3:0], 2'b00});
				chars[n + 3] = PAD_CHAR;
				n += 4;
				advance_line();
			end
			// closing newline only when the line holds something
			if (wrap_en && line_count != 8'd0) begin
				chars[n] = NEWLINE_CHAR;
				n++;
			end
			held_bytes = '0;
			group_fill = 2'd0;
			line_count = '0;
		end
		for (int i = 0; i < n; i++) begin
			item.ch   = chars[i];
			item.last = last && (i == n - 1);
			expected_chars.insert(expected_chars.size(), item);
		end
	endfunction

	// Driver: offers queued bytes, predicts at each accepted request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_if.valid <= 1'b0;
		end else begin
			if (byte_if.valid && byte_if.ready) begin
				encode_byte(byte_if.in_byte, byte_if.is_last);
			end
			// payload holds while a request waits on ready
			if (!byte_if.valid || byte_if.ready) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_req = pending_bytes.pop_front();
					byte_if.valid   <= 1'b1;
					byte_if.in_byte <= next_req.data;
					byte_if.is_last <= next_req.last;
				end else begin
					byte_if.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted character against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_if.ready <= 1'b0;
		end else begin
			if (char_if.valid && char_if.ready) begin
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected char: expected none, got %h/%b", $time,
						char_if.out_char, char_if.out_last);
					mismatch_count++;
				end else begin
					if (char_if.out_char !== expected_chars[0].ch) begin
						$display("%0t: out_char mismatch: expected %h, got %h", $time,
							expected_chars[0].ch, char_if.out_char);
						mismatch_count++;
					end
					if (char_if.out_last !== expected_chars[0].last) begin
						$display("%0t: out_last mismatch: expected %b, got %b", $time,
							expected_chars[0].last, char_if.out_last);
						mismatch_count++;
					end
					void'(expected_chars.pop_front());
				end
			end
			char_if.ready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Long receiver hold-off, started once by the main sequence.
	initial begin
		wait (stall_trigger === 1'b1);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (LONG_STALL) @(posedge clk);
		hold_rx <= 1'b0;
	end

	// Watchdog: any handshake on any channel counts as progress.
	initial begin : watchdog
		int stuck;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (byte_if.valid && byte_if.ready) || (char_if.valid && char_if.ready)
					|| (cfg_if.valid && cfg_if.ready)) begin
				stuck = 0;
			end else begin
				stuck++;
			end
		end
		$display("tb_base64_encoder_line_wrap: errors");
		$finish;
	end

	task automatic push_byte(input logic [7:0] b, input logic last);
		byte_req_t req;
		req.data = b;
		req.last = last;
		pending_bytes.insert(pending_bytes.size(), req);
	endtask

	// Sender goes quiet until every expected character has come, then settles.
	task automatic drain();
		while (pending_bytes.size() != 0 || byte_if.valid || expected_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write; valid stays up across back-to-back writes.
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		if (idx == CFG_WRAP_LENGTH) begin
			wrap_len = val;
		end else begin
			wrap_en = val[0];
		end
	endtask

	// Both registers, block idle. Upper data bits of the enable write are junk.
	task automatic set_wrap(input logic [7:0] len, input logic en);
		logic [7:0] en_word;
		en_word    = 8'($urandom_range(255));
		en_word[0] = en;
		write_reg(CFG_WRAP_LENGTH, len);
		write_reg(CFG_WRAP_ENABLE, en_word);
		cfg_if.valid <= 1'b0;
	endtask

	// Random messages until the phase has queued about target bytes.
	task automatic run_phase(input int unsigned s_idle, input int unsigned r_idle,
			input logic [7:0] len, input logic en, input int target, input int first_len);
		int queued;
		int msg_len;
		set_wrap(len, en);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		queued = 0;
		while (queued < target) begin
			if (queued == 0 && first_len != 0) begin
				msg_len = first_len;
			end else if ($urandom_range(99) < 70) begin
				msg_len = $urandom_range(16, 1);
			end else begin
				msg_len = $urandom_range(60, 17);
			end
			if (queued + msg_len > target) begin
				msg_len = target - queued;
			end
			for (int i = 0; i < msg_len; i++) begin
				push_byte(8'($urandom_range(255)), i == msg_len - 1);
			end
			queued += msg_len;
		end
		drain();
	endtask

	initial begin
		// every input known from time zero
		arst_n          = 1'b0;
		byte_if.valid   = 1'b0;
		byte_if.in_byte = '0;
		byte_if.is_last = 1'b0;
		char_if.ready   = 1'b0;
		cfg_if.valid    = 1'b0;
		cfg_if.index    = CFG_WRAP_LENGTH;
		cfg_if.data     = '0;
		stall_trigger   = 1'b0;
		hold_rx         = 1'b0;
		send_idle_pct   = 24;
		recv_idle_pct   = 69;
		mismatch_count  = 0;
		held_bytes      = '0;
		group_fill      = 2'd0;
		line_count      = '0;
		wrap_len        = WRAP_LENGTH_RST;
		wrap_en         = WRAP_ENABLE_RST;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed, reset register values first ---
		// one-byte message: two pads
		push_byte(8'h00, 1'b1);
		// two-byte message: one pad
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b1);
		// full group closing the message
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b1);
		drain();

		// shortest legal line: newline after every group
		set_wrap(8'd4, 1'b1);
		push_byte(8'h01, 1'b0);
		push_byte(8'h02, 1'b0);
		push_byte(8'h03, 1'b0);
		push_byte(8'hFB, 1'b1);
		drain();

		// wrapping off: no closing newline either
		set_wrap(8'd0, 1'b0);
		push_byte(8'h10, 1'b0);
		push_byte(8'hEF, 1'b1);
		drain();

		// wrap length below the group size
		set_wrap(8'd2, 1'b1);
		push_byte(8'hBE, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h7F, 1'b0);
		push_byte(8'h55, 1'b1);
		drain();

		// wrapping switched back on in mid-message, count already past the length
		set_wrap(8'd4, 1'b0);
		for (int i = 0; i < 6; i++) begin
			push_byte(8'($urandom_range(255)), 1'b0);
		end
		drain();
		set_wrap(8'd4, 1'b1);
		push_byte(8'h3C, 1'b0);
		push_byte(8'hC3, 1'b0);
		push_byte(8'h0F, 1'b0);
		push_byte(8'hF0, 1'b1);
		drain();

		// --- random ---
		// sender idles lightly, receiver heavily
		run_phase(24, 69, 8'($urandom_range(252, 4)), 1'b1, 25, 0);
		// the other way round, longest legal line
		run_phase(69, 24, 8'd252, 1'b1, 25, 0);
		// no idling; receiver held off so the block backs up; long first message
		// drives the line count into saturation with a length only saturation reaches
		stall_trigger = 1'b1;
		run_phase(0, 0, 8'd255, 1'b1, 200, 200);
		// wrapping off, saturation again with no newline at all
		run_phase(0, 0, 8'($urandom_range(255)), 1'b0, 195, 195);
		// back to the shortest line
		run_phase(0, 0, 8'd4, 1'b1, 10, 0);

		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && expected_chars.size() == 0) begin
			$display("tb_base64_encoder_line_wrap: clean");
		end else begin
			$display("tb_base64_encoder_line_wrap: errors");
		end
		$finish;
	end

endmodule
`default_nettype wire
